/* rtl/gwm_pkg.sv */
package gwm_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_SUBJECT = 2'd2,
    CMD_END     = 2'd3
  } cmd_t;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_ANY  = 8'h3F;
  localparam logic [7:0] CH_NUL  = 8'h00;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic overflowed;
  } out_item_t;

endpackage

/* rtl/gwm_in_if.sv */
interface gwm_in_if import gwm_pkg::*; ();
  logic       valid;
  logic       ready;
  cmd_t       cmd;
  logic [7:0] byte_value;

  modport source (output valid, output cmd, output byte_value, input ready);
  modport sink (input valid, input cmd, input byte_value, output ready);
endinterface

/* rtl/gwm_out_if.sv */
interface gwm_out_if import gwm_pkg::*; ();
  logic valid;
  logic ready;
  logic matched;
  logic overflowed;

  modport source (output valid, output matched, output overflowed, input ready);
  modport sink (input valid, input matched, input overflowed, output ready);
endinterface

/* rtl/gwm_in_stage.sv */
module gwm_in_stage import gwm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     take,
  output logic     item_valid,
  output in_item_t item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

/* rtl/gwm_engine.sv */
module gwm_engine import gwm_pkg::*; #(
  parameter int PATTERN_MAX = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_valid,
  input  in_item_t  item,
  input  logic      out_room,
  output logic      take,
  output logic      push,
  output out_item_t result
);

  localparam int PW = PATTERN_MAX + 1;
  localparam int LW = $clog2(PATTERN_MAX + 1);

  logic [7:0]             store_r [PATTERN_MAX];
  logic [LW-1:0]          len_r, len_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [PATTERN_MAX-1:0] star_r, star_nxt;
  logic [PATTERN_MAX-1:0] any_r, any_nxt;
  logic [PATTERN_MAX-1:0] used_r, used_nxt;
  logic [PW-1:0]          restart_r, restart_nxt;
  logic [PW-1:0]          active_r, active_nxt;

  logic                   full;
  logic                   app_star;
  logic                   wr_en;
  logic [PATTERN_MAX-1:0] wr_sel;
  logic [PATTERN_MAX-1:0] lit_hit;
  logic [PW-1:0]          step;
  logic [PW-1:0]          prop;
  logic [PW-1:0]          closed;
  logic [PW-1:0]          restart_app;

  assign take = item_valid && ((item.cmd != CMD_END) || out_room);
  assign push = take && (item.cmd == CMD_END);

  assign result.matched    = active_r[len_r];
  assign result.overflowed = ovf_r;

  assign full     = (len_r == LW'(PATTERN_MAX));
  assign app_star = (item.byte_value == CH_STAR);
  assign wr_sel   = PATTERN_MAX'(1) << len_r;
  assign wr_en    = take && (item.cmd == CMD_APPEND) && (item.byte_value != CH_NUL) && !full;

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      lit_hit[i] = used_r[i] && !star_r[i] && (any_r[i] || (store_r[i] == item.byte_value));
    end
  end

  // stars hold their position, literal hits advance one, then close over star runs
  assign step   = {1'b0, active_r[PATTERN_MAX-1:0] & star_r}
                | {active_r[PATTERN_MAX-1:0] & lit_hit, 1'b0};
  assign prop   = {1'b0, star_r};
  assign closed = step | (((step & prop) + prop) ^ prop);

  assign restart_app = restart_r
                     | ((restart_r[len_r] && app_star) ? (PW'(1) << (len_r + LW'(1)))
                                                        : PW'(0));

  always_comb begin
    len_nxt     = len_r;
    ovf_nxt     = ovf_r;
    star_nxt    = star_r;
    any_nxt     = any_r;
    used_nxt    = used_r;
    restart_nxt = restart_r;
    active_nxt  = active_r;
    if (take) begin
      unique case (item.cmd)
        CMD_CLEAR: begin
          len_nxt     = '0;
          ovf_nxt     = 1'b0;
          star_nxt    = '0;
          any_nxt     = '0;
          used_nxt    = '0;
          restart_nxt = PW'(1);
          active_nxt  = PW'(1);
        end
        CMD_APPEND: begin
          if (item.byte_value != CH_NUL) begin
            if (!full) begin
              len_nxt     = len_r + LW'(1);
              used_nxt    = used_r | wr_sel;
              star_nxt    = star_r | (app_star ? wr_sel : '0);
              any_nxt     = any_r | ((item.byte_value == CH_ANY) ? wr_sel : '0);
              restart_nxt = restart_app;
              active_nxt  = restart_app;
            end else begin
              ovf_nxt    = 1'b1;
              active_nxt = restart_r;
            end
          end
        end
        CMD_SUBJECT: begin
          active_nxt = closed;
        end
        CMD_END: begin
          active_nxt = restart_r;
        end
        default: begin
          active_nxt = active_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      ovf_r     <= 1'b0;
      star_r    <= '0;
      any_r     <= '0;
      used_r    <= '0;
      restart_r <= PW'(1);
      active_r  <= PW'(1);
    end else begin
      len_r     <= len_nxt;
      ovf_r     <= ovf_nxt;
      star_r    <= star_nxt;
      any_r     <= any_nxt;
      used_r    <= used_nxt;
      restart_r <= restart_nxt;
      active_r  <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (wr_en && wr_sel[i]) begin
        store_r[i] <= item.byte_value;
      end
    end
  end

endmodule

/* rtl/gwm_out_stage.sv */
module gwm_out_stage import gwm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t result,
  output logic      out_room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  assign out_room  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= result;
    end
  end

endmodule

/* rtl/glob_wildcard_matcher.sv */
// Channel   Dir  Transaction contents
// in_ch     in   cmd, byte_value: clear, append pattern byte, subject byte, end
// out_ch    out  matched, overflowed: one per end-of-string transaction
//
// One transaction per cycle while the result register has room: an input register,
// a position-vector update (star-run closure is a single add), a result register.
// A result is registered as its end-of-string transaction leaves the input register.
// Reset (rst_n low, synchronous) empties the pattern and both registers.
// An end-of-string transaction waits in the input register while the result
// register is full and not being taken; later transactions wait behind it.
module glob_wildcard_matcher import gwm_pkg::*; #(
  parameter int PATTERN_MAX = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  gwm_in_if.sink    in_ch,
  gwm_out_if.source out_ch
);

  in_item_t  in_item;
  in_item_t  item;
  out_item_t result;
  out_item_t out_item;
  logic      item_valid;
  logic      take;
  logic      push;
  logic      out_room;

  assign in_item.cmd        = in_ch.cmd;
  assign in_item.byte_value = in_ch.byte_value;

  gwm_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  gwm_engine #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_room   (out_room),
    .take       (take),
    .push       (push),
    .result     (result)
  );

  gwm_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .result    (result),
    .out_room  (out_room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign out_ch.matched    = out_item.matched;
  assign out_ch.overflowed = out_item.overflowed;

endmodule
